### design/tma_pkg.sv
// shared widths, constants and controller/datapath link types for the triangle area block
package tma_pkg;

    localparam int COORD_W       = 25;
    localparam int SIDE_W        = 26;
    localparam int AREA_W        = 34;
    localparam int SUM_W         = 48;
    localparam int PROD_W        = 109;
    localparam int HALF_W        = 28;
    localparam int FRAC_BITS_DEF = 16;

    typedef struct packed {
        logic       load;
        logic       sq_en;
        logic [1:0] idx;
        logic       side_start;
        logic       sort_en;
        logic       fact_en;
        logic       pmul_en;
        logic       wmul_en;
        logic       area_start;
        logic       fin_en;
    } tma_cmd_t;

    typedef struct packed {
        logic side_done;
        logic area_done;
    } tma_sts_t;

endpackage

### design/tma_isqrt.sv
// bit-serial integer square root, one result bit per cycle
module tma_isqrt #(
    parameter int ROOT_W = 26
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic [ROOT_W-1:0]     root,
    output logic                  done
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ROOT_W+3:0]   cur;
    logic [ROOT_W+3:0]   trial;
    logic                ge;

    always_comb begin
        cur   = {rem_reg, rad_reg[2*ROOT_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        ge    = (cur >= trial);
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[2*ROOT_W-3:0], 2'b00};
            rem_next  = ge ? (ROOT_W+2)'(cur - trial) : cur[ROOT_W+1:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

### design/tma_datapath.sv
// datapath: squared distances, side roots, sort, heron factors, wide product, area, total
module tma_datapath #(
    parameter int FRAC_BITS = tma_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tma_pkg::tma_cmd_t                     cmd,
    output tma_pkg::tma_sts_t                     sts,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert0_x,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert0_y,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert0_z,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert1_x,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert1_y,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert1_z,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert2_x,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert2_y,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert2_z,
    input  logic                                  s_last_face,
    output logic [tma_pkg::AREA_W-1:0]            m_face_area,
    output logic                                  m_degenerate,
    output logic [tma_pkg::SUM_W-1:0]             m_total_area,
    output logic                                  m_total_done
);

    localparam int CW    = tma_pkg::COORD_W;
    localparam int SW    = tma_pkg::SIDE_W;
    localparam int AW    = tma_pkg::AREA_W;
    localparam int UW    = tma_pkg::SUM_W;
    localparam int PW    = tma_pkg::PROD_W;
    localparam int HW    = tma_pkg::HALF_W;
    localparam int SHIFT = 2 * FRAC_BITS + 4;

    logic signed [CW-1:0] v0_reg [3];
    logic signed [CW-1:0] v1_reg [3];
    logic signed [CW-1:0] v2_reg [3];
    logic                 last_reg;
    logic [2*SW-1:0]      d2_reg [3];
    logic [SW-1:0]        a_reg, b_reg, c_reg;
    logic [SW+1:0]        f1_reg;
    logic [SW:0]          f2_reg, f3_reg, f4_reg;
    logic                 neg_reg, degen_reg;
    logic [54:0]          p12_reg;
    logic [53:0]          p34_reg;
    logic [PW-1:0]        prod_reg;
    logic                 sat_reg;
    logic [UW-1:0]        sum_reg;
    logic [AW-1:0]        face_reg;
    logic                 odegen_reg;
    logic [UW-1:0]        total_reg;
    logic                 done_reg;

    logic [1:0]           comp;
    logic [2*SW-1:0]      sq [3];
    logic [SW-1:0]        root [3];
    logic [2:0]           side_done;
    logic [SW-1:0]        mx, mn, md;
    logic [SW+1:0]        sum3;
    logic signed [SW+2:0] f1, f2, f3, f4;
    logic [HW-1:0]        pa, pb;
    logic [2*HW-1:0]      pp;
    logic [PW-1:0]        pp_sh;
    logic [PW-1:0]        q;
    logic [AW-1:0]        area_root;
    logic                 area_done;
    logic [AW-1:0]        face;
    logic [UW:0]          tsum;
    logic [UW-1:0]        total;

    // one coordinate component per step, three side lanes in parallel
    always_comb begin
        logic signed [CW:0] dl [3];
        logic [CW:0]        mg [3];
        comp = (cmd.idx == 2'd3) ? 2'd0 : cmd.idx;
        dl[0] = {v0_reg[comp][CW-1], v0_reg[comp]} - {v1_reg[comp][CW-1], v1_reg[comp]};
        dl[1] = {v0_reg[comp][CW-1], v0_reg[comp]} - {v2_reg[comp][CW-1], v2_reg[comp]};
        dl[2] = {v1_reg[comp][CW-1], v1_reg[comp]} - {v2_reg[comp][CW-1], v2_reg[comp]};
        for (int k = 0; k < 3; k++) begin
            mg[k] = dl[k][CW] ? (CW+1)'(-dl[k]) : (CW+1)'(dl[k]);
            sq[k] = mg[k] * mg[k];
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_side
            tma_isqrt #(.ROOT_W(SW)) u_side (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .start    (cmd.side_start),
                .radicand (d2_reg[g]),
                .root     (root[g]),
                .done     (side_done[g])
            );
        end
    endgenerate

    // sort the three sides
    always_comb begin
        mx = (root[0] > root[1]) ? root[0] : root[1];
        mx = (mx > root[2]) ? mx : root[2];
        mn = (root[0] < root[1]) ? root[0] : root[1];
        mn = (mn < root[2]) ? mn : root[2];
        sum3 = (SW+2)'(root[0]) + (SW+2)'(root[1]) + (SW+2)'(root[2])
             - (SW+2)'(mx) - (SW+2)'(mn);
        md = sum3[SW-1:0];
    end

    always_comb begin
        f1 = $signed({3'b000, a_reg}) + ($signed({3'b000, b_reg}) + $signed({3'b000, c_reg}));
        f2 = $signed({3'b000, c_reg}) - ($signed({3'b000, a_reg}) - $signed({3'b000, b_reg}));
        f3 = $signed({3'b000, c_reg}) + ($signed({3'b000, a_reg}) - $signed({3'b000, b_reg}));
        f4 = $signed({3'b000, a_reg}) + ($signed({3'b000, b_reg}) - $signed({3'b000, c_reg}));
    end

    // 55x54 product as four 28x28 partial products
    always_comb begin
        pa = cmd.idx[1] ? HW'(p12_reg[54:HW]) : p12_reg[HW-1:0];
        pb = cmd.idx[0] ? HW'(p34_reg[53:HW]) : p34_reg[HW-1:0];
        pp = pa * pb;
        pp_sh = PW'(pp) << (HW * (int'(cmd.idx[1]) + int'(cmd.idx[0])));
    end

    assign q = prod_reg >> SHIFT;

    tma_isqrt #(.ROOT_W(AW)) u_area (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.area_start),
        .radicand (q[2*AW-1:0]),
        .root     (area_root),
        .done     (area_done)
    );

    always_comb begin
        if (neg_reg)
            face = '0;
        else if (sat_reg)
            face = '1;
        else
            face = area_root;
        tsum  = (UW+1)'(sum_reg) + (UW+1)'(face);
        total = tsum[UW] ? '1 : tsum[UW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v0_reg[0] <= s_vert0_x; v0_reg[1] <= s_vert0_y; v0_reg[2] <= s_vert0_z;
            v1_reg[0] <= s_vert1_x; v1_reg[1] <= s_vert1_y; v1_reg[2] <= s_vert1_z;
            v2_reg[0] <= s_vert2_x; v2_reg[1] <= s_vert2_y; v2_reg[2] <= s_vert2_z;
            last_reg  <= s_last_face;
            for (int k = 0; k < 3; k++)
                d2_reg[k] <= '0;
        end else if (cmd.sq_en) begin
            for (int k = 0; k < 3; k++)
                d2_reg[k] <= d2_reg[k] + sq[k];
        end
        if (cmd.sort_en) begin
            a_reg <= mx;
            b_reg <= md;
            c_reg <= mn;
        end
        if (cmd.fact_en) begin
            f1_reg    <= f1[SW+1:0];
            f2_reg    <= f2[SW:0];
            f3_reg    <= f3[SW:0];
            f4_reg    <= f4[SW:0];
            neg_reg   <= f2[SW+2];
            degen_reg <= f2[SW+2] && (f1 != 0) && (f3 != 0) && (f4 != 0);
        end
        if (cmd.pmul_en) begin
            p12_reg <= f1_reg * f2_reg;
            p34_reg <= f3_reg * f4_reg;
        end
        if (cmd.wmul_en)
            prod_reg <= (cmd.idx == 2'd0) ? pp_sh : prod_reg + pp_sh;
        if (cmd.area_start)
            sat_reg <= |q[PW-1:2*AW];
        if (cmd.fin_en) begin
            face_reg   <= face;
            odegen_reg <= degen_reg;
            total_reg  <= total;
            done_reg   <= last_reg;
        end
        if (!aresetn)
            sum_reg <= '0;
        else if (cmd.fin_en)
            sum_reg <= last_reg ? '0 : total;
    end

    assign sts.side_done = &side_done;
    assign sts.area_done = area_done;

    assign m_face_area  = face_reg;
    assign m_degenerate = odegen_reg;
    assign m_total_area = total_reg;
    assign m_total_done = done_reg;

endmodule

### design/tma_ctrl.sv
// controller state machine sequencing the area datapath and the result handshake
module tma_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output tma_pkg::tma_cmd_t cmd,
    input  tma_pkg::tma_sts_t sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_SIDE0 = 4'd2;
    localparam logic [3:0] S_SIDE  = 4'd3;
    localparam logic [3:0] S_SORT  = 4'd4;
    localparam logic [3:0] S_FACT  = 4'd5;
    localparam logic [3:0] S_PMUL  = 4'd6;
    localparam logic [3:0] S_WMUL  = 4'd7;
    localparam logic [3:0] S_AREA0 = 4'd8;
    localparam logic [3:0] S_AREA  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       mv_reg, mv_next;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    idx_next   = 2'd0;
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                cmd.sq_en = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == 2'd2)
                    state_next = S_SIDE0;
            end
            S_SIDE0: begin
                cmd.side_start = 1'b1;
                state_next     = S_SIDE;
            end
            S_SIDE: begin
                if (sts.side_done)
                    state_next = S_SORT;
            end
            S_SORT: begin
                cmd.sort_en = 1'b1;
                state_next  = S_FACT;
            end
            S_FACT: begin
                cmd.fact_en = 1'b1;
                state_next  = S_PMUL;
            end
            S_PMUL: begin
                cmd.pmul_en = 1'b1;
                idx_next    = 2'd0;
                state_next  = S_WMUL;
            end
            S_WMUL: begin
                cmd.wmul_en = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == 2'd3)
                    state_next = S_AREA0;
            end
            S_AREA0: begin
                cmd.area_start = 1'b1;
                state_next     = S_AREA;
            end
            S_AREA: begin
                if (sts.area_done)
                    state_next = S_FIN;
            end
            S_FIN: begin
                if (!mv_reg || m_ready) begin
                    cmd.fin_en = 1'b1;
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= 2'd0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;

endmodule

### design/triangle_mesh_area_accumulator_unit.sv
// top level of the triangle mesh area accumulator
//
// usage
// - input channel s_*: one request is one triangle, three vertices in signed
//   fixed point (FRAC_BITS fraction bits) plus s_last_face
// - result channel m_*: one result per triangle with the face area, the
//   degenerate flag, the running mesh total and total_done (= last face)
// - each request spends most of its time in the two bit-serial square
//   root passes (26 steps for the side lengths, run three wide, and 34
//   steps for the area); the rest goes to squares, sort, factors and a
//   four-step wide product
// - one triangle is worked on at a time; s_ready is high only while idle
// - a new request is taken only after the previous one has left the
//   last step and the controller is back in idle
// - a finished result sits in the output register; a new request is taken
//   while it waits, and the next result holds in the last step until the
//   receiver takes the previous one (m_ready low stalls only that step)
// - reset clears the controller, the result valid and the mesh total
// - a last face request resets the mesh total after its result is formed
module triangle_mesh_area_accumulator_unit #(
    parameter int FRAC_BITS = tma_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert0_x,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert0_y,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert0_z,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert1_x,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert1_y,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert1_z,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert2_x,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert2_y,
    input  logic signed [tma_pkg::COORD_W-1:0]    s_vert2_z,
    input  logic                                  s_last_face,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [tma_pkg::AREA_W-1:0]            m_face_area,
    output logic                                  m_degenerate,
    output logic [tma_pkg::SUM_W-1:0]             m_total_area,
    output logic                                  m_total_done
);

    // command and status link between sequencer and datapath
    tma_pkg::tma_cmd_t cmd;
    tma_pkg::tma_sts_t sts;

    // sequencer: request handshake, step order, result valid
    tma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // arithmetic, mesh total and result registers
    tma_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_vert0_x    (s_vert0_x),
        .s_vert0_y    (s_vert0_y),
        .s_vert0_z    (s_vert0_z),
        .s_vert1_x    (s_vert1_x),
        .s_vert1_y    (s_vert1_y),
        .s_vert1_z    (s_vert1_z),
        .s_vert2_x    (s_vert2_x),
        .s_vert2_y    (s_vert2_y),
        .s_vert2_z    (s_vert2_z),
        .s_last_face  (s_last_face),
        .m_face_area  (m_face_area),
        .m_degenerate (m_degenerate),
        .m_total_area (m_total_area),
        .m_total_done (m_total_done)
    );

endmodule

### tb/tb_triangle_mesh_area_accumulator_unit.sv
// self-checking testbench for the triangle mesh area accumulator
module tb_triangle_mesh_area_accumulator_unit;

    localparam int CW = tma_pkg::COORD_W;
    localparam int AW = tma_pkg::AREA_W;
    localparam int UW = tma_pkg::SUM_W;
    localparam int FB = tma_pkg::FRAC_BITS_DEF;

    // one triangle request as the sender drives it
    typedef struct {
        logic [CW-1:0] crd [9];   // v0 x,y,z  v1 x,y,z  v2 x,y,z
        logic          last;
    } tri_req_t;

    // one result as the block returns it
    typedef struct packed {
        logic [AW-1:0] face;
        logic          degen;
        logic [UW-1:0] total;
        logic          done;
    } area_res_t;

    // directed row: request plus an optional hand-typed result
    typedef struct {
        tri_req_t  req;
        bit        typed;
        area_res_t res;
    } dir_row_t;

    localparam int PHASE_ITEMS = 450;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CW-1:0] s_crd [9];
    logic s_last_face = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [AW-1:0] m_face_area;
    logic m_degenerate;
    logic [UW-1:0] m_total_area;
    logic m_total_done;

    // predictor state: the running mesh total
    logic [UW-1:0]    mesh_sum;
    area_res_t        pending_areas [$];
    int               send_idle_pct = 14;
    int               recv_idle_pct = 87;
    bit               hold_off_req = 1'b0;
    int               errors = 0;
    int               quiet_cycles = 0;

    always #1 aclk = ~aclk;

    initial begin
        for (int i = 0; i < 9; i++) s_crd[i] = '0;
    end

    triangle_mesh_area_accumulator_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_vert0_x(s_crd[0]), .s_vert0_y(s_crd[1]), .s_vert0_z(s_crd[2]),
        .s_vert1_x(s_crd[3]), .s_vert1_y(s_crd[4]), .s_vert1_z(s_crd[5]),
        .s_vert2_x(s_crd[6]), .s_vert2_y(s_crd[7]), .s_vert2_z(s_crd[8]),
        .s_last_face(s_last_face),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_face_area(m_face_area), .m_degenerate(m_degenerate),
        .m_total_area(m_total_area), .m_total_done(m_total_done)
    );

    // floor square root, 34 result bits are enough for every use here
    function automatic logic [63:0] floor_sqrt(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = AW - 1; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= x) r = c;
        end
        return r;
    endfunction

    // side lengths, stable heron area and the running total for one triangle
    function automatic area_res_t heron_face_area(tri_req_t t);
        area_res_t   r;
        longint      p [9];
        longint      s [3];
        longint      d, d2, a, b, c, f1, f2, f3, f4;
        logic [127:0] prod, q;
        logic [UW:0] sum;
        int          pi [3] = '{0, 0, 3};
        int          qi [3] = '{3, 6, 6};
        for (int i = 0; i < 9; i++) p[i] = longint'($signed(t.crd[i]));
        for (int k = 0; k < 3; k++) begin
            d2 = 0;
            for (int j = 0; j < 3; j++) begin
                d = p[pi[k] + j] - p[qi[k] + j];
                d2 += d * d;
            end
            s[k] = longint'(floor_sqrt(128'(d2)));
        end
        a = s[0] > s[1] ? s[0] : s[1];
        a = a > s[2] ? a : s[2];
        c = s[0] < s[1] ? s[0] : s[1];
        c = c < s[2] ? c : s[2];
        b = s[0] + s[1] + s[2] - a - c;
        f1 = a + (b + c);
        f2 = c - (a - b);
        f3 = c + (a - b);
        f4 = a + (b - c);
        r.face = '0;
        r.degen = 1'b0;
        if (f2 < 0) begin
            // negative middle factor: area forced to zero, flagged unless another factor is zero
            r.degen = (f1 != 0) && (f3 != 0) && (f4 != 0);
        end else begin
            prod = 128'(f1 * f2) * 128'(f3 * f4);
            q = prod >> (2 * FB + 4);
            if (q >= (128'd1 << (2 * AW))) r.face = '1;
            else r.face = AW'(floor_sqrt(q));
        end
        sum = {1'b0, mesh_sum} + (UW + 1)'(r.face);
        r.total = sum[UW] ? '1 : sum[UW-1:0];
        r.done = t.last;
        mesh_sum = t.last ? '0 : r.total;
        return r;
    endfunction

    function automatic tri_req_t make_tri(longint v [9], bit last);
        tri_req_t t;
        for (int i = 0; i < 9; i++) t.crd[i] = v[i][CW-1:0];
        t.last = last;
        return t;
    endfunction

    // random triangle: full-range noise, tight local shapes, near-collinear
    function automatic tri_req_t rand_tri();
        tri_req_t t;
        int mode, k, m;
        logic [CW-1:0] d;
        mode = $urandom_range(9);
        k = $urandom_range(20);
        m = $urandom_range(2, 5);
        for (int j = 0; j < 3; j++) t.crd[j] = CW'($urandom());
        for (int j = 0; j < 3; j++) begin
            if (mode < 3) begin
                t.crd[3 + j] = CW'($urandom());
                t.crd[6 + j] = CW'($urandom());
            end else if (mode < 8) begin
                t.crd[3 + j] = t.crd[j] + CW'($urandom_range(2 << k) - (1 << k));
                t.crd[6 + j] = t.crd[j] + CW'($urandom_range(2 << k) - (1 << k));
            end else begin
                d = CW'($urandom_range(2 << k) - (1 << k));
                t.crd[3 + j] = t.crd[j] + d;
                t.crd[6 + j] = CW'(t.crd[j] + d * m + CW'($urandom_range(2) - 1));
            end
        end
        t.last = ($urandom_range(19) == 0);
        return t;
    endfunction

    // append one expected result behind the older ones
    function automatic void queue_expect(area_res_t r);
        pending_areas = {pending_areas, r};
    endfunction

    // offer one request and wait for its acceptance
    task automatic send_tri(tri_req_t t, bit typed, area_res_t typed_res);
        area_res_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        for (int i = 0; i < 9; i++) s_crd[i] = t.crd[i];
        s_last_face = t.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = heron_face_area(t);
        queue_expect(typed ? typed_res : r);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // receiver: random ready, with a long hold-off on request
    initial begin
        @(negedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            m_ready = ($urandom_range(99) >= recv_idle_pct);
            @(negedge aclk);
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        area_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_areas.size() == 0) begin
                $display("%0t unexpected result face=%0d degen=%0b total=%0d done=%0b",
                         $time, m_face_area, m_degenerate, m_total_area, m_total_done);
                errors++;
            end else begin
                e = pending_areas.pop_front();
                if (m_face_area !== e.face) begin
                    $display("%0t face_area exp %0d got %0d", $time, e.face, m_face_area);
                    errors++;
                end
                if (m_degenerate !== e.degen) begin
                    $display("%0t degenerate exp %0b got %0b", $time, e.degen, m_degenerate);
                    errors++;
                end
                if (m_total_area !== e.total) begin
                    $display("%0t total_area exp %0d got %0d", $time, e.total, m_total_area);
                    errors++;
                end
                if (m_total_done !== e.done) begin
                    $display("%0t total_done exp %0b got %0b", $time, e.done, m_total_done);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no request and no result moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        dir_row_t  rows [$];
        dir_row_t  row;
        area_res_t nores;
        longint    S;
        longint    mx, mn;
        S = longint'(1) << FB;
        mx = (longint'(1) << (CW - 1)) - 1;
        mn = -(longint'(1) << (CW - 1));
        nores = '0;
        mesh_sum = '0;

        // point triangle, then again as the last face
        row.req = make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0);
        row.typed = 1'b1;
        row.res = '{face: '0, degen: 1'b0, total: '0, done: 1'b0};
        rows = {rows, row};
        row.req = make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1);
        row.res = '{face: '0, degen: 1'b0, total: '0, done: 1'b1};
        rows = {rows, row};
        // exact collinear: middle factor is zero, area zero, no flag
        row.req = make_tri('{0, 0, 0, S, 0, 0, 2 * S, 0, 0}, 1'b0);
        row.res = '{face: '0, degen: 1'b0, total: '0, done: 1'b0};
        rows = {rows, row};
        // 3-4-5 right triangle, area 6
        row.req = make_tri('{0, 0, 0, 3 * S, 0, 0, 0, 4 * S, 0}, 1'b0);
        row.res = '{face: AW'(6 * S), degen: 1'b0, total: UW'(6 * S), done: 1'b0};
        rows = {rows, row};
        // rounded side lengths break the triangle inequality: degenerate flag
        row.req = make_tri('{0, 0, 0, 1, 1, 1, 3, 3, 3}, 1'b0);
        row.res = '{face: '0, degen: 1'b1, total: UW'(6 * S), done: 1'b0};
        rows = {rows, row};
        // coordinate extremes, checked against the predictor
        row.typed = 1'b0; row.res = nores;
        row.req = make_tri('{mn, mn, mn, mx, mn, mn, mn, mx, mx}, 1'b0);
        rows = {rows, row};
        row.req = make_tri('{mx, mx, mx, mn, mx, mx, mx, mn, mn}, 1'b0);
        rows = {rows, row};
        row.req = make_tri('{mn, mn, mn, mx, mx, mx, mn, mx, mn}, 1'b0);
        rows = {rows, row};
        row.req = make_tri('{mx, mx, mx, mx, mx, mx, mx, mx, mx}, 1'b0);
        rows = {rows, row};
        row.req = make_tri('{mn, 0, mx, 0, mx, mn, mx, mn, 0}, 1'b0);
        rows = {rows, row};
        row.req = make_tri('{-1, -1, -1, 1, -1, -1, -1, 1, -1}, 1'b1);
        rows = {rows, row};
        row.req = make_tri('{mn, mn, 0, mx, mn, 0, mn, mx, 0}, 1'b1);
        rows = {rows, row};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) send_tri(rows[i].req, rows[i].typed, rows[i].res);

        for (int ph = 0; ph < 3; ph++) begin
            // sender waits until the block has drained before each phase
            while (pending_areas.size() != 0) @(negedge aclk);
            send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 87 : 0;
            recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 14 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while requests keep coming
                if (ph == 0 && n == 20) hold_off_req = 1'b1;
                send_tri(rand_tri(), 1'b0, nores);
            end
        end

        while (pending_areas.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

### filelist.f
design/tma_pkg.sv
design/tma_isqrt.sv
design/tma_datapath.sv
design/tma_ctrl.sv
design/triangle_mesh_area_accumulator_unit.sv
tb/tb_triangle_mesh_area_accumulator_unit.sv
